// File: src/rfts_pkg.sv
// rfts_pkg: shared types, constants and helpers of the range flow table switch
// used by rfts_cell and range_flow_table_switch_unit; no dependencies
`default_nettype none

package rfts_pkg;

   // table geometry and field widths
   localparam int TABLE_DEPTH = 16;
   localparam int MAX_ADDRESS = 1000;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 10;
   localparam int SW_W        = 3;
   localparam int HOP_W       = 4;
   localparam int CNT_W       = 16;
   localparam int KIND_W      = 3;
   localparam int MODE_W      = 2;
   localparam int FIELD_IDX_W = 4;

   // reset values of the configuration registers
   localparam logic [SW_W-1:0]   SWITCH_ID_RESET  = SW_W'(1);
   localparam logic [ADDR_W-1:0] LOCAL_LOW_RESET  = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] LOCAL_HIGH_RESET = ADDR_W'(1000);

   typedef enum logic [1:0] {
      ACT_FORWARD = 2'd0,
      ACT_DELIVER = 2'd1,
      ACT_DROP    = 2'd2
   } act_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PACKET = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_READ   = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FORWARD = 3'd0,
      KIND_DELIVER = 3'd1,
      KIND_DROP    = 3'd2,
      KIND_QUERY   = 3'd3,
      KIND_ADDED   = 3'd4,
      KIND_FULL    = 3'd5,
      KIND_READ    = 3'd6,
      KIND_INVALID = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DONE
   } state_type;

   // broadcast from the controller to every table cell
   typedef struct packed {
      logic              look;
      logic              commit;
      logic              install;
      logic              src_ok;
      logic [ADDR_W-1:0] dst;
      logic [USED_W-1:0] used;
      logic [ADDR_W-1:0] new_low;
      logic [ADDR_W-1:0] new_high;
      act_type           new_action;
      logic [SW_W-1:0]   new_target;
   } cell_ctl_type;

   // what one cell shows back to the controller
   typedef struct packed {
      logic [ADDR_W-1:0] low;
      logic [ADDR_W-1:0] high;
      act_type           action;
      logic [SW_W-1:0]   target;
      logic [CNT_W-1:0]  count;
      logic              first;
   } cell_stat_type;

   // neighbor toward the target switch in the linear chain
   function automatic logic [HOP_W-1:0] next_hop(input logic [SW_W-1:0] target,
                                                 input logic [SW_W-1:0] sid);
      logic [HOP_W-1:0] up;
      logic [HOP_W-1:0] down;
      logic [HOP_W-1:0] tgt;
      up   = HOP_W'(sid) + HOP_W'(1);
      down = (sid == '0) ? '0 : HOP_W'(sid) - HOP_W'(1);
      tgt  = HOP_W'(target);
      if (tgt == up || (sid != '0 && tgt == down)) begin
         next_hop = tgt;
      end else if (target > sid) begin
         next_hop = up;
      end else begin
         next_hop = down;
      end
   endfunction

endpackage

`default_nettype wire

// File: src/rfts_cell.sv
// rfts_cell: one flow table entry with range compare, hit count and first-hit chain link
// depends on rfts_pkg
`default_nettype none

module rfts_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [rfts_pkg::IDX_W-1:0] cell_index,
   input  wire rfts_pkg::cell_ctl_type     ctl,
   input  wire logic                       hit_in,
   output logic                            hit_out,
   output rfts_pkg::cell_stat_type         stat
);
   import rfts_pkg::*;

   logic [ADDR_W-1:0] low_ff;
   logic [ADDR_W-1:0] high_ff;
   act_type           action_ff;
   logic [SW_W-1:0]   target_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              match_ff;
   logic              in_use;
   logic              first;
   logic              write_here;

   assign in_use     = {1'b0, cell_index} < ctl.used;
   assign write_here = ctl.install && ({1'b0, cell_index} == ctl.used);

   // first-hit chain: a cell wins only when no lower entry matched
   assign hit_out = hit_in | match_ff;
   assign first   = match_ff & ~hit_in;

   // range compare, registered while look is set
   always_ff @(posedge clock) begin
      if (ctl.look) begin
         match_ff <= in_use && ctl.src_ok && (low_ff <= ctl.dst) && (ctl.dst <= high_ff);
      end
   end

   // entry contents are written only when the rule is installed
   always_ff @(posedge clock) begin
      if (write_here) begin
         low_ff    <= ctl.new_low;
         high_ff   <= ctl.new_high;
         action_ff <= ctl.new_action;
         target_ff <= ctl.new_target;
      end
   end

   // saturating hit count, set to one when the rule is installed
   always_comb begin
      count_in = count_ff;
      if (write_here) begin
         count_in = CNT_W'(1);
      end else if (ctl.commit && first && count_ff != '1) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.low    = low_ff;
   assign stat.high   = high_ff;
   assign stat.action = action_ff;
   assign stat.target = target_ff;
   assign stat.count  = count_ff;
   assign stat.first  = first;

endmodule

`default_nettype wire

// File: src/range_flow_table_switch_unit.sv
// range_flow_table_switch_unit: top level, item control, local rule, pending packet, csr
// depends on rfts_pkg and rfts_cell
// an accepted request beat passes the look state (range compare, registered in each
// cell) and the done state (first-hit chain, select and update); its result beat is
// registered once the output is free; new beats are taken only in idle or as done ends
// reset: table counts cleared, one rule in use (local), no pending packet, csr to defaults
`default_nettype none

module range_flow_table_switch_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [rfts_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [rfts_pkg::ADDR_W-1:0]       req_src_ip,
   input  wire logic [rfts_pkg::ADDR_W-1:0]       req_dst_ip,
   input  wire logic                              req_rule_is_drop,
   input  wire logic [rfts_pkg::ADDR_W-1:0]       req_rule_dst_low,
   input  wire logic [rfts_pkg::ADDR_W-1:0]       req_rule_dst_high,
   input  wire logic [rfts_pkg::SW_W-1:0]         req_rule_switch,
   input  wire logic [rfts_pkg::FIELD_IDX_W-1:0]  req_entry_index,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [rfts_pkg::KIND_W-1:0]            rsp_kind,
   output logic [rfts_pkg::HOP_W-1:0]             rsp_next_switch,
   output logic [rfts_pkg::ADDR_W-1:0]            rsp_out_src,
   output logic [rfts_pkg::ADDR_W-1:0]            rsp_out_dst,
   output logic [rfts_pkg::FIELD_IDX_W-1:0]       rsp_hit_index,
   output logic [rfts_pkg::ADDR_W-1:0]            rsp_entry_dst_low,
   output logic [rfts_pkg::ADDR_W-1:0]            rsp_entry_dst_high,
   output logic [1:0]                             rsp_entry_action,
   output logic [rfts_pkg::SW_W-1:0]              rsp_entry_target,
   output logic [rfts_pkg::CNT_W-1:0]             rsp_entry_count,
   // configuration port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [3:0]                        paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   import rfts_pkg::*;

   localparam logic [1:0] REG_SWITCH_ID  = 2'd0;
   localparam logic [1:0] REG_LOCAL_LOW  = 2'd1;
   localparam logic [1:0] REG_LOCAL_HIGH = 2'd2;

   // configuration registers
   logic [SW_W-1:0]   switch_id_ff;
   logic [ADDR_W-1:0] local_low_ff;
   logic [ADDR_W-1:0] local_high_ff;
   logic              csr_write;

   // control
   state_type state_ff;
   state_type state_in;
   logic      req_fire;
   logic      out_free;
   logic      done_fire;
   logic      look;

   // request beat held through the look and done states
   logic [MODE_W-1:0]      mode_ff;
   logic [ADDR_W-1:0]      src_ff;
   logic [ADDR_W-1:0]      dst_ff;
   logic                   is_drop_ff;
   logic [ADDR_W-1:0]      rlow_ff;
   logic [ADDR_W-1:0]      rhigh_ff;
   logic [SW_W-1:0]        rsw_ff;
   logic [FIELD_IDX_W-1:0] idx_ff;

   // table state outside the cells
   logic [USED_W-1:0] used_ff;
   logic [USED_W-1:0] used_in;
   logic [CNT_W-1:0]  count0_ff;
   logic [CNT_W-1:0]  count0_in;
   logic              local_match_ff;
   logic [ADDR_W-1:0] pend_src_ff;
   logic [ADDR_W-1:0] pend_dst_ff;
   logic              pend_valid_ff;
   logic [ADDR_W-1:0] pend_src_in;
   logic [ADDR_W-1:0] pend_dst_in;
   logic              pend_valid_in;

   // cell row
   cell_ctl_type  ctl;
   cell_stat_type stat [1:TABLE_DEPTH-1];
   logic          chain [0:TABLE_DEPTH-1];
   logic          src_ok;
   logic          table_full;
   logic          hit;
   logic [IDX_W-1:0] hit_idx;
   logic [IDX_W-1:0] sel_idx;
   logic [ADDR_W-1:0] sel_low;
   logic [ADDR_W-1:0] sel_high;
   act_type           sel_action;
   logic [SW_W-1:0]   sel_target;
   logic [CNT_W-1:0]  sel_count;
   logic              commit;
   logic              install;

   // response register
   logic                   rsp_valid_ff;
   kind_type               kind_ff;
   kind_type               kind_in;
   logic [HOP_W-1:0]       next_sw_ff;
   logic [HOP_W-1:0]       next_sw_in;
   logic [ADDR_W-1:0]      out_src_ff;
   logic [ADDR_W-1:0]      out_src_in;
   logic [ADDR_W-1:0]      out_dst_ff;
   logic [ADDR_W-1:0]      out_dst_in;
   logic [FIELD_IDX_W-1:0] hit_index_ff;
   logic [FIELD_IDX_W-1:0] hit_index_in;
   logic [ADDR_W-1:0]      e_low_ff;
   logic [ADDR_W-1:0]      e_low_in;
   logic [ADDR_W-1:0]      e_high_ff;
   logic [ADDR_W-1:0]      e_high_in;
   logic [1:0]             e_action_ff;
   logic [1:0]             e_action_in;
   logic [SW_W-1:0]        e_target_ff;
   logic [SW_W-1:0]        e_target_in;
   logic [CNT_W-1:0]       e_count_ff;
   logic [CNT_W-1:0]       e_count_in;

   // csr access
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_id_ff  <= SWITCH_ID_RESET;
         local_low_ff  <= LOCAL_LOW_RESET;
         local_high_ff <= LOCAL_HIGH_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_SWITCH_ID:  switch_id_ff  <= pwdata[SW_W-1:0];
            REG_LOCAL_LOW:  local_low_ff  <= pwdata[ADDR_W-1:0];
            REG_LOCAL_HIGH: local_high_ff <= pwdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SWITCH_ID:  prdata = 32'(switch_id_ff);
         REG_LOCAL_LOW:  prdata = 32'(local_low_ff);
         REG_LOCAL_HIGH: prdata = 32'(local_high_ff);
         default:        prdata = '0;
      endcase
   end

   // handshake
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_fire = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_LOOK;
         ST_LOOK: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = req_fire ? ST_LOOK : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // state outputs
   always_comb begin
      look      = 1'b0;
      done_fire = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_LOOK: look = 1'b1;
         ST_DONE: begin
            done_fire = out_free;
            req_stall = !out_free;
         end
         default: ;
      endcase
   end

   // capture the request beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= req_mode;
         src_ff     <= req_src_ip;
         dst_ff     <= req_dst_ip;
         is_drop_ff <= req_rule_is_drop;
         rlow_ff    <= req_rule_dst_low;
         rhigh_ff   <= req_rule_dst_high;
         rsw_ff     <= req_rule_switch;
         idx_ff     <= req_entry_index;
      end
   end

   // local delivery rule is entry 0, compared alongside the cells
   assign src_ok = 32'(src_ff) <= 32'(MAX_ADDRESS);

   always_ff @(posedge clock) begin
      if (look) begin
         local_match_ff <= src_ok && (local_low_ff <= dst_ff) && (dst_ff <= local_high_ff);
      end
   end

   // broadcast to the cell row
   assign table_full = 32'(used_ff) >= 32'(TABLE_DEPTH);
   assign commit     = done_fire && (mode_ff == MODE_PACKET) && hit;
   assign install    = done_fire && (mode_ff == MODE_ADD) && !table_full;

   assign ctl.look       = look;
   assign ctl.commit     = commit;
   assign ctl.install    = install;
   assign ctl.src_ok     = src_ok;
   assign ctl.dst        = dst_ff;
   assign ctl.used       = used_ff;
   assign ctl.new_low    = rlow_ff;
   assign ctl.new_high   = is_drop_ff ? rlow_ff : rhigh_ff;
   assign ctl.new_action = is_drop_ff ? ACT_DROP : ACT_FORWARD;
   assign ctl.new_target = is_drop_ff ? '0 : rsw_ff;

   assign chain[0] = local_match_ff;

   for (genvar g = 1; g < TABLE_DEPTH; g++) begin : g_cell
      rfts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(g)),
         .ctl        (ctl),
         .hit_in     (chain[g-1]),
         .hit_out    (chain[g]),
         .stat       (stat[g])
      );
   end

   assign hit = chain[TABLE_DEPTH-1];

   // one-hot first hit to index
   always_comb begin
      hit_idx = '0;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         if (stat[i].first) hit_idx = hit_idx | IDX_W'(i);
      end
   end

   // entry select for packet action or table read
   assign sel_idx = (mode_ff == MODE_READ) ? IDX_W'(idx_ff) : hit_idx;

   always_comb begin
      sel_low    = local_low_ff;
      sel_high   = local_high_ff;
      sel_action = ACT_DELIVER;
      sel_target = '0;
      sel_count  = count0_ff;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         if (sel_idx == IDX_W'(i)) begin
            sel_low    = stat[i].low;
            sel_high   = stat[i].high;
            sel_action = stat[i].action;
            sel_target = stat[i].target;
            sel_count  = stat[i].count;
         end
      end
   end

   // result and state update for the item in its last cycle
   always_comb begin
      kind_in       = KIND_INVALID;
      next_sw_in    = '0;
      out_src_in    = '0;
      out_dst_in    = '0;
      hit_index_in  = '0;
      e_low_in      = '0;
      e_high_in     = '0;
      e_action_in   = '0;
      e_target_in   = '0;
      e_count_in    = '0;
      used_in       = used_ff;
      pend_src_in   = pend_src_ff;
      pend_dst_in   = pend_dst_ff;
      pend_valid_in = pend_valid_ff;
      case (mode_ff)
         MODE_PACKET: begin
            out_src_in = src_ff;
            out_dst_in = dst_ff;
            if (hit) begin
               hit_index_in = FIELD_IDX_W'(hit_idx);
               case (sel_action)
                  ACT_FORWARD: begin
                     kind_in    = KIND_FORWARD;
                     next_sw_in = next_hop(sel_target, switch_id_ff);
                  end
                  ACT_DELIVER: kind_in = KIND_DELIVER;
                  default:     kind_in = KIND_DROP;
               endcase
            end else begin
               kind_in       = KIND_QUERY;
               pend_src_in   = src_ff;
               pend_dst_in   = dst_ff;
               pend_valid_in = 1'b1;
            end
         end
         MODE_ADD: begin
            if (table_full) begin
               kind_in = KIND_FULL;
            end else begin
               used_in      = used_ff + USED_W'(1);
               hit_index_in = FIELD_IDX_W'(used_ff);
               if (pend_valid_ff) begin
                  out_src_in = pend_src_ff;
                  out_dst_in = pend_dst_ff;
               end
               if (!is_drop_ff && pend_valid_ff) begin
                  kind_in    = KIND_FORWARD;
                  next_sw_in = next_hop(rsw_ff, switch_id_ff);
               end else begin
                  kind_in = KIND_ADDED;
               end
               pend_valid_in = 1'b0;
               pend_src_in   = '0;
               pend_dst_in   = '0;
            end
         end
         MODE_READ: begin
            hit_index_in = idx_ff;
            if (32'(idx_ff) < 32'(used_ff)) begin
               kind_in     = KIND_READ;
               e_low_in    = sel_low;
               e_high_in   = sel_high;
               e_action_in = sel_action;
               e_target_in = sel_target;
               e_count_in  = sel_count;
            end
         end
         default: kind_in = KIND_INVALID;
      endcase
   end

   // entry 0 hit count
   always_comb begin
      count0_in = count0_ff;
      if (commit && local_match_ff && count0_ff != '1) begin
         count0_in = count0_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= USED_W'(1);
         count0_ff     <= '0;
         pend_src_ff   <= '0;
         pend_dst_ff   <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         count0_ff <= count0_in;
         if (done_fire) begin
            used_ff       <= used_in;
            pend_src_ff   <= pend_src_in;
            pend_dst_ff   <= pend_dst_in;
            pend_valid_ff <= pend_valid_in;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         kind_ff      <= kind_in;
         next_sw_ff   <= next_sw_in;
         out_src_ff   <= out_src_in;
         out_dst_ff   <= out_dst_in;
         hit_index_ff <= hit_index_in;
         e_low_ff     <= e_low_in;
         e_high_ff    <= e_high_in;
         e_action_ff  <= e_action_in;
         e_target_ff  <= e_target_in;
         e_count_ff   <= e_count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_next_switch    = next_sw_ff;
   assign rsp_out_src        = out_src_ff;
   assign rsp_out_dst        = out_dst_ff;
   assign rsp_hit_index      = hit_index_ff;
   assign rsp_entry_dst_low  = e_low_ff;
   assign rsp_entry_dst_high = e_high_ff;
   assign rsp_entry_action   = e_action_ff;
   assign rsp_entry_target   = e_target_ff;
   assign rsp_entry_count    = e_count_ff;

   // rule count stays between the local rule alone and a full table
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff >= USED_W'(1) && 32'(used_ff) <= 32'(TABLE_DEPTH))
      else $error("rule count out of range");

   // an accepted beat always starts the compare cycle
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_LOOK)
      else $error("accepted beat did not enter compare");

   // a miss leaves a pending packet behind
   a_miss_pending: assert property (@(posedge clock) disable iff (reset)
      (done_fire && mode_ff == MODE_PACKET && !hit) |=> pend_valid_ff)
      else $error("miss did not hold the packet");

   // a finished item always produces a response beat
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      done_fire |=> rsp_valid_ff)
      else $error("finished item without response beat");

endmodule

`default_nettype wire

// File: tb/range_flow_table_switch_unit_tb.sv
// range_flow_table_switch_unit_tb: self-checking bench for the range flow table switch
// drives request beats and csr writes, predicts every result beat and compares it
// depends on rfts_pkg and range_flow_table_switch_unit
`default_nettype none

module range_flow_table_switch_unit_tb;
   import rfts_pkg::*;

   // csr map and the mode code the package leaves unnamed
   localparam int REG_SWITCH_ID  = 0;
   localparam int REG_LOCAL_LOW  = 1;
   localparam int REG_LOCAL_HIGH = 2;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [MODE_W-1:0]      mode;
      logic [ADDR_W-1:0]      src;
      logic [ADDR_W-1:0]      dst;
      logic                   is_drop;
      logic [ADDR_W-1:0]      rlo;
      logic [ADDR_W-1:0]      rhi;
      logic [SW_W-1:0]        rsw;
      logic [FIELD_IDX_W-1:0] idx;
   } switch_req_type;

   typedef struct packed {
      kind_type               kind;
      logic [HOP_W-1:0]       next_switch;
      logic [ADDR_W-1:0]      out_src;
      logic [ADDR_W-1:0]      out_dst;
      logic [FIELD_IDX_W-1:0] hit_index;
      logic [ADDR_W-1:0]      entry_low;
      logic [ADDR_W-1:0]      entry_high;
      logic [1:0]             entry_action;
      logic [SW_W-1:0]        entry_target;
      logic [CNT_W-1:0]       entry_count;
   } route_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   wire logic              req_stall;
   logic [MODE_W-1:0]      req_mode = '0;
   logic [ADDR_W-1:0]      req_src_ip = '0;
   logic [ADDR_W-1:0]      req_dst_ip = '0;
   logic                   req_rule_is_drop = 1'b0;
   logic [ADDR_W-1:0]      req_rule_dst_low = '0;
   logic [ADDR_W-1:0]      req_rule_dst_high = '0;
   logic [SW_W-1:0]        req_rule_switch = '0;
   logic [FIELD_IDX_W-1:0] req_entry_index = '0;

   wire logic                   rsp_valid;
   logic                        rsp_stall = 1'b0;
   wire logic [KIND_W-1:0]      rsp_kind;
   wire logic [HOP_W-1:0]       rsp_next_switch;
   wire logic [ADDR_W-1:0]      rsp_out_src;
   wire logic [ADDR_W-1:0]      rsp_out_dst;
   wire logic [FIELD_IDX_W-1:0] rsp_hit_index;
   wire logic [ADDR_W-1:0]      rsp_entry_dst_low;
   wire logic [ADDR_W-1:0]      rsp_entry_dst_high;
   wire logic [1:0]             rsp_entry_action;
   wire logic [SW_W-1:0]        rsp_entry_target;
   wire logic [CNT_W-1:0]       rsp_entry_count;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   wire logic [31:0] prdata;
   wire logic        pready;

   range_flow_table_switch_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_src_ip         (req_src_ip),
      .req_dst_ip         (req_dst_ip),
      .req_rule_is_drop   (req_rule_is_drop),
      .req_rule_dst_low   (req_rule_dst_low),
      .req_rule_dst_high  (req_rule_dst_high),
      .req_rule_switch    (req_rule_switch),
      .req_entry_index    (req_entry_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_next_switch    (rsp_next_switch),
      .rsp_out_src        (rsp_out_src),
      .rsp_out_dst        (rsp_out_dst),
      .rsp_hit_index      (rsp_hit_index),
      .rsp_entry_dst_low  (rsp_entry_dst_low),
      .rsp_entry_dst_high (rsp_entry_dst_high),
      .rsp_entry_action   (rsp_entry_action),
      .rsp_entry_target   (rsp_entry_target),
      .rsp_entry_count    (rsp_entry_count),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // shadow of the switch: csr, flow table, pending packet
   logic [SW_W-1:0]   cfg_switch_id  = SWITCH_ID_RESET;
   logic [ADDR_W-1:0] cfg_local_low  = LOCAL_LOW_RESET;
   logic [ADDR_W-1:0] cfg_local_high = LOCAL_HIGH_RESET;
   logic [ADDR_W-1:0] rule_lo   [TABLE_DEPTH];
   logic [ADDR_W-1:0] rule_hi   [TABLE_DEPTH];
   act_type           rule_act  [TABLE_DEPTH];
   logic [SW_W-1:0]   rule_tgt  [TABLE_DEPTH];
   logic [CNT_W-1:0]  rule_hits [TABLE_DEPTH] = '{default: '0};
   int                rules_used = 1;
   logic [ADDR_W-1:0] held_src = '0;
   logic [ADDR_W-1:0] held_dst = '0;
   logic              held_valid = 1'b0;

   switch_req_type pending_requests [$];
   route_beat_type expected_routes [$];
   int             span_lo [$];
   int             span_hi [$];

   logic mismatch_seen = 1'b0;
   logic calm = 1'b0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int   req_gap = 0;
   int   rsp_hold = 0;
   int   cycle_count = 0;

   // clock, period 8
   initial begin
      forever #4 clock = ~clock;
   end

   // neighbor toward a target switch in the chain
   function automatic logic [HOP_W-1:0] hop_toward(input logic [SW_W-1:0] target);
      int sid;
      int tgt;
      int below;
      sid   = int'(cfg_switch_id);
      tgt   = int'(target);
      below = (sid == 0) ? 0 : sid - 1;
      if (tgt == sid + 1 || (sid != 0 && tgt == below)) return HOP_W'(tgt);
      if (tgt > sid) return HOP_W'(sid + 1);
      return HOP_W'(below);
   endfunction

   // expected result of one request beat, updates the shadow state
   function automatic route_beat_type route_item(input switch_req_type rq);
      route_beat_type rs;
      int n;
      int hit;
      int slot;
      int lo;
      int hi;
      act_type act;
      rs = '0;
      case (rq.mode)
         MODE_PACKET: begin
            hit = -1;
            n = (rules_used < TABLE_DEPTH) ? rules_used : TABLE_DEPTH;
            // source range of every rule is 0..MAX_ADDRESS
            if (int'(rq.src) <= MAX_ADDRESS) begin
               for (int i = 0; i < n && hit < 0; i++) begin
                  lo = (i == 0) ? int'(cfg_local_low) : int'(rule_lo[i]);
                  hi = (i == 0) ? int'(cfg_local_high) : int'(rule_hi[i]);
                  if (lo <= int'(rq.dst) && int'(rq.dst) <= hi) hit = i;
               end
            end
            rs.out_src = rq.src;
            rs.out_dst = rq.dst;
            if (hit >= 0) begin
               if (rule_hits[hit] != COUNT_MAX) rule_hits[hit] = rule_hits[hit] + 16'd1;
               rs.hit_index = FIELD_IDX_W'(hit);
               act = (hit == 0) ? ACT_DELIVER : rule_act[hit];
               case (act)
                  ACT_FORWARD: begin
                     rs.kind = KIND_FORWARD;
                     rs.next_switch = hop_toward(rule_tgt[hit]);
                  end
                  ACT_DELIVER: rs.kind = KIND_DELIVER;
                  default:     rs.kind = KIND_DROP;
               endcase
            end else begin
               // miss: query the controller, newest miss is the pending one
               rs.kind = KIND_QUERY;
               held_src = rq.src;
               held_dst = rq.dst;
               held_valid = 1'b1;
            end
         end
         MODE_ADD: begin
            if (rules_used >= TABLE_DEPTH) begin
               rs.kind = KIND_FULL;
            end else begin
               slot = rules_used;
               rule_lo[slot]   = rq.rlo;
               rule_hi[slot]   = rq.is_drop ? rq.rlo : rq.rhi;
               rule_act[slot]  = rq.is_drop ? ACT_DROP : ACT_FORWARD;
               rule_tgt[slot]  = rq.is_drop ? '0 : rq.rsw;
               rule_hits[slot] = 16'd1;
               rules_used++;
               rs.hit_index = FIELD_IDX_W'(slot);
               if (held_valid) begin
                  rs.out_src = held_src;
                  rs.out_dst = held_dst;
               end
               // forward rule releases the pending packet, drop rule discards it
               if (!rq.is_drop && held_valid) begin
                  rs.kind = KIND_FORWARD;
                  rs.next_switch = hop_toward(rq.rsw);
               end else begin
                  rs.kind = KIND_ADDED;
               end
               held_valid = 1'b0;
               held_src = '0;
               held_dst = '0;
            end
         end
         MODE_READ: begin
            rs.hit_index = rq.idx;
            if (int'(rq.idx) < rules_used) begin
               rs.kind = KIND_READ;
               if (rq.idx == '0) begin
                  rs.entry_low    = cfg_local_low;
                  rs.entry_high   = cfg_local_high;
                  rs.entry_action = ACT_DELIVER;
                  rs.entry_target = '0;
               end else begin
                  rs.entry_low    = rule_lo[rq.idx];
                  rs.entry_high   = rule_hi[rq.idx];
                  rs.entry_action = rule_act[rq.idx];
                  rs.entry_target = rule_tgt[rq.idx];
               end
               rs.entry_count = rule_hits[rq.idx];
            end else begin
               rs.kind = KIND_INVALID;
            end
         end
         default: rs.kind = KIND_INVALID;
      endcase
      return rs;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   // request beat with every field random, the mode then picks what matters
   function automatic switch_req_type noise_req();
      switch_req_type rq;
      rq.mode    = MODE_W'($urandom);
      rq.src     = ADDR_W'($urandom);
      rq.dst     = ADDR_W'($urandom);
      rq.is_drop = 1'($urandom);
      rq.rlo     = ADDR_W'($urandom);
      rq.rhi     = ADDR_W'($urandom);
      rq.rsw     = SW_W'($urandom);
      rq.idx     = FIELD_IDX_W'($urandom);
      return rq;
   endfunction

   function automatic switch_req_type make_packet(input int src, input int dst);
      switch_req_type rq;
      rq = noise_req();
      rq.mode = MODE_PACKET;
      rq.src  = ADDR_W'(src);
      rq.dst  = ADDR_W'(dst);
      return rq;
   endfunction

   function automatic switch_req_type make_add(input int drop, input int lo, input int hi,
                                               input int sw);
      switch_req_type rq;
      rq = noise_req();
      rq.mode    = MODE_ADD;
      rq.is_drop = 1'(drop);
      rq.rlo     = ADDR_W'(lo);
      rq.rhi     = ADDR_W'(hi);
      rq.rsw     = SW_W'(sw);
      return rq;
   endfunction

   function automatic switch_req_type make_read(input int idx);
      switch_req_type rq;
      rq = noise_req();
      rq.mode = MODE_READ;
      rq.idx  = FIELD_IDX_W'(idx);
      return rq;
   endfunction

   function automatic switch_req_type make_spare();
      switch_req_type rq;
      rq = noise_req();
      rq.mode = MODE_SPARE;
      return rq;
   endfunction

   // mostly legal sources, now and then one above the address range
   function automatic int pick_src();
      if ($urandom_range(0, 19) == 0) return int'($urandom_range(1001, 1023));
      return int'($urandom_range(0, 1000));
   endfunction

   // request driver: next beat once the current one is taken and the gap is over
   always @(negedge clock) begin : drive_req
      switch_req_type rq;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || req_taken) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_requests.size() != 0) begin
            rq = pending_requests.pop_front();
            req_mode          <= rq.mode;
            req_src_ip        <= rq.src;
            req_dst_ip        <= rq.dst;
            req_rule_is_drop  <= rq.is_drop;
            req_rule_dst_low  <= rq.rlo;
            req_rule_dst_high <= rq.rhi;
            req_rule_switch   <= rq.rsw;
            req_entry_index   <= rq.idx;
            req_valid <= 1'b1;
            req_gap <= calm ? 0 : int'($urandom_range(0, 4));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall: hold off for the drawn number of cycles after each beat
   always @(negedge clock) begin : drive_stall
      int hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_taken) begin
         hold = calm ? 0 : int'($urandom_range(0, 4));
         rsp_stall <= (hold != 0);
         rsp_hold <= (hold != 0) ? hold - 1 : 0;
      end else if (rsp_hold != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: check result beats, predict accepted request beats
   always @(posedge clock) begin : watch_beats
      switch_req_type rq;
      route_beat_type want;
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_routes.size() == 0) begin
               $error("result beat with no request waiting, kind %0d", rsp_kind);
               mismatch_seen = 1'b1;
            end else begin
               want = expected_routes.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("next_switch", 32'(want.next_switch), 32'(rsp_next_switch));
               check_field("out_src", 32'(want.out_src), 32'(rsp_out_src));
               check_field("out_dst", 32'(want.out_dst), 32'(rsp_out_dst));
               check_field("hit_index", 32'(want.hit_index), 32'(rsp_hit_index));
               check_field("entry_dst_low", 32'(want.entry_low), 32'(rsp_entry_dst_low));
               check_field("entry_dst_high", 32'(want.entry_high), 32'(rsp_entry_dst_high));
               check_field("entry_action", 32'(want.entry_action), 32'(rsp_entry_action));
               check_field("entry_target", 32'(want.entry_target), 32'(rsp_entry_target));
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
            end
         end
         if (req_valid && !req_stall) begin
            rq.mode    = req_mode;
            rq.src     = req_src_ip;
            rq.dst     = req_dst_ip;
            rq.is_drop = req_rule_is_drop;
            rq.rlo     = req_rule_dst_low;
            rq.rhi     = req_rule_dst_high;
            rq.rsw     = req_rule_switch;
            rq.idx     = req_entry_index;
            expected_routes.push_back(route_item(rq));
         end
      end
   end

   // csr write: setup then access, shadow updated at the write edge
   task automatic csr_write(input int index, input int value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 4'(4 * index);
      pwdata  <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         REG_SWITCH_ID:  cfg_switch_id  = SW_W'(value);
         REG_LOCAL_LOW:  cfg_local_low  = ADDR_W'(value);
         REG_LOCAL_HIGH: cfg_local_high = ADDR_W'(value);
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // sender holds off until every queued beat has its result back
   task automatic wait_quiet();
      while (pending_requests.size() != 0 || req_valid || expected_routes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // random traffic: packets, miss-then-rule pairs, loose rules, reads, spare mode
   task automatic queue_random(input int count);
      int r;
      int k;
      int dst;
      int lo;
      int hi;
      int drop;
      for (k = 0; k < count; k++) begin
         r = int'($urandom_range(0, 99));
         if (r < 50) begin
            if (span_lo.size() != 0 && $urandom_range(0, 99) < 35) begin
               lo = int'($urandom_range(0, span_lo.size() - 1));
               dst = int'($urandom_range(span_lo[lo], span_hi[lo]));
            end else if (cfg_local_low <= cfg_local_high && $urandom_range(0, 99) < 30) begin
               dst = int'($urandom_range(cfg_local_low, cfg_local_high));
            end else begin
               dst = int'($urandom_range(0, 1023));
            end
            pending_requests.push_back(make_packet(pick_src(), dst));
         end else if (r < 55) begin
            dst = int'($urandom_range(0, 1000));
            lo = dst - int'($urandom_range(0, 20));
            hi = dst + int'($urandom_range(0, 20));
            if (lo < 0) lo = 0;
            if (hi > 1023) hi = 1023;
            pending_requests.push_back(make_packet(pick_src(), dst));
            pending_requests.push_back(make_add(0, lo, hi, int'($urandom_range(1, 7))));
            span_lo.push_back(lo);
            span_hi.push_back(hi);
         end else if (r < 59) begin
            drop = int'($urandom_range(0, 1));
            lo = int'($urandom_range(0, 1023));
            hi = int'($urandom_range(0, 1023));
            pending_requests.push_back(make_add(drop, lo, hi, int'($urandom_range(0, 7))));
            if (drop != 0) hi = lo;
            if (lo <= hi) begin
               span_lo.push_back(lo);
               span_hi.push_back(hi);
            end
         end else if (r < 93) begin
            pending_requests.push_back(make_read(int'($urandom_range(0, 15))));
         end else begin
            pending_requests.push_back(make_spare());
         end
      end
   endtask

   // phases: settings of switch id and local range, extremes included
   int phase_sid  [6] = '{7, 4, 1, 3, 6, 2};
   int phase_low  [6] = '{0, 1000, 0, 600, 250, 900};
   int phase_high [6] = '{0, 1000, 1000, 400, 750, 1000};

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(REG_SWITCH_ID, 1);
      csr_write(REG_LOCAL_LOW, 100);
      csr_write(REG_LOCAL_HIGH, 199);

      // directed: local hit, misses incl. source out of range, reads, spare mode
      pending_requests.push_back(make_packet(0, 150));
      pending_requests.push_back(make_packet(1000, 1000));
      pending_requests.push_back(make_packet(1023, 150));
      pending_requests.push_back(make_packet(5, 0));
      pending_requests.push_back(make_read(0));
      pending_requests.push_back(make_read(1));
      pending_requests.push_back(make_spare());
      // forward rule releases the pending packet, then a hit on it
      pending_requests.push_back(make_add(0, 0, 50, 7));
      pending_requests.push_back(make_packet(7, 20));
      // drop rules with and without a pending packet
      pending_requests.push_back(make_add(1, 300, 777, 5));
      pending_requests.push_back(make_packet(9, 300));
      pending_requests.push_back(make_packet(9, 301));
      pending_requests.push_back(make_add(1, 301, 0, 0));
      // odd ranges and targets stored as given
      pending_requests.push_back(make_add(0, 500, 400, 0));
      pending_requests.push_back(make_add(0, 1023, 1023, 1));
      pending_requests.push_back(make_packet(1, 1023));
      pending_requests.push_back(make_packet(0, 1000));
      pending_requests.push_back(make_read(1));
      pending_requests.push_back(make_read(5));
      pending_requests.push_back(make_read(15));
      pending_requests.push_back(make_read(0));
      pending_requests.push_back(make_add(0, 990, 1000, 0));
      pending_requests.push_back(make_packet(1000, 1000));
      pending_requests.push_back(make_packet(1000, 995));
      wait_quiet();

      // random phases, each split by a full drain
      for (int p = 0; p < 6; p++) begin
         csr_write(REG_SWITCH_ID, phase_sid[p]);
         csr_write(REG_LOCAL_LOW, phase_low[p]);
         csr_write(REG_LOCAL_HIGH, phase_high[p]);
         calm = (p % 3 == 2);
         queue_random(100);
         wait_quiet();
         queue_random(100);
         wait_quiet();
      end
      calm = 1'b0;
      repeat (8) @(posedge clock);

      if (!mismatch_seen && expected_routes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
src/rfts_pkg.sv
src/rfts_cell.sv
src/range_flow_table_switch_unit.sv
tb/range_flow_table_switch_unit_tb.sv
